// File: rtl/scfp_pkg.sv
// Shared types, character codes and the three-character field decoder
// for the serial coordinate frame parser. No dependencies.
`default_nettype none

package scfp_pkg;

  localparam int FrameLen = 12;
  localparam int CmdLen   = 4;
  localparam int PosW     = 4;

  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_S     = 8'h73;  // 's'
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic signed [10:0] CMD_SET   = 11'sd111;
  localparam logic signed [10:0] CMD_CLEAR = 11'sd100;

  localparam logic MODE_COORD = 1'b0;
  localparam logic MODE_CMD   = 1'b1;
  localparam logic KIND_COORD = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  typedef enum logic [1:0] {PH_LEAD, PH_DIGITS, PH_DONE} decode_phase_t;

  // completed frame handed from the byte assembler to the decoder
  typedef struct packed {
    logic                 kind;
    logic [11:0][7:0]     bytes;
  } frame_t;

  // result item, format_ok in bit 0
  typedef struct packed {
    logic                 pad;
    logic                 work_enable;
    logic signed [10:0]   command_value;
    logic                 data_valid;
    logic signed [10:0]   sum_value;
    logic signed [10:0]   length_value;
    logic signed [10:0]   angle_value;
    logic                 format_ok;
  } result_t;

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  // atoi over exactly three characters: blanks, optional sign, digits
  function automatic logic signed [10:0] decode3(input logic [7:0] c0,
                                                 input logic [7:0] c1,
                                                 input logic [7:0] c2);
    logic [2:0][7:0] ch;
    decode_phase_t   phase;
    logic            neg;
    logic [9:0]      mag;
    logic [3:0]      dig;
    ch    = {c2, c1, c0};
    phase = PH_LEAD;
    neg   = 1'b0;
    mag   = 10'd0;
    for (int i = 0; i < 3; i++) begin
      dig = 4'(ch[i] - CH_ZERO);
      case (phase)
        PH_LEAD: begin
          if (is_blank(ch[i])) begin
            phase = PH_LEAD;
          end else if (ch[i] == CH_PLUS || ch[i] == CH_MINUS) begin
            neg   = (ch[i] == CH_MINUS);
            phase = PH_DIGITS;
          end else if (is_digit(ch[i])) begin
            mag   = 10'(dig);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit(ch[i])) begin
            mag = 10'(14'(mag) * 14'd10 + 14'(dig));
          end else begin
            phase = PH_DONE;
          end
        end
        default: phase = PH_DONE;
      endcase
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

// File: rtl/scfp_assembler.sv
// Byte assembler: holds the mode register, byte position and frame buffers,
// and registers each completed frame for the decoder. Uses scfp_pkg.
`default_nettype none

module scfp_assembler
  import scfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  output logic            frame_valid,
  output frame_t          frame,
  input  wire logic       frame_ready
);

  logic                  frame_mode;
  logic [PosW-1:0]       byte_position;
  logic [PosW-1:0]       byte_position_next;
  logic [FrameLen-1:0][7:0] coord_buf;
  logic [FrameLen-1:0][7:0] coord_buf_next;
  logic [CmdLen-1:0][7:0]   cmd_buf;
  logic [CmdLen-1:0][7:0]   cmd_buf_next;
  logic                  accept;
  logic                  done;
  frame_t                frame_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = !frame_valid || frame_ready;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    coord_buf_next     = coord_buf;
    cmd_buf_next       = cmd_buf;
    byte_position_next = byte_position;
    done               = 1'b0;
    if (accept) begin
      if (frame_mode == MODE_COORD) begin
        if (s_tdata == CH_A) begin
          coord_buf_next[0]  = s_tdata;
          byte_position_next = PosW'(1);
        end else if (byte_position < PosW'(FrameLen)) begin
          coord_buf_next[byte_position] = s_tdata;
          if (byte_position == PosW'(FrameLen - 1)) begin
            byte_position_next = '0;
            done               = 1'b1;
          end else begin
            byte_position_next = byte_position + PosW'(1);
          end
        end
      end else begin
        if (s_tdata == CH_S) begin
          cmd_buf_next[0]    = s_tdata;
          byte_position_next = PosW'(1);
        end else if (cmd_buf[0] == CH_S && byte_position < PosW'(CmdLen)) begin
          cmd_buf_next[byte_position[1:0]] = s_tdata;
          if (byte_position == PosW'(CmdLen - 1)) begin
            byte_position_next = '0;
            done               = 1'b1;
          end else begin
            byte_position_next = byte_position + PosW'(1);
          end
        end
      end
    end
  end

  // command frames ride in the low four bytes
  always_comb begin
    frame_next.kind  = (frame_mode == MODE_CMD) ? KIND_CMD : KIND_COORD;
    frame_next.bytes = coord_buf_next;
    if (frame_mode == MODE_CMD) begin
      frame_next.bytes = '0;
      for (int i = 0; i < CmdLen; i++) begin
        frame_next.bytes[i] = cmd_buf_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode    <= MODE_COORD;
      byte_position <= '0;
      coord_buf     <= '0;
      cmd_buf       <= '0;
      frame_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_mode <= cfg_data;
      end
      byte_position <= byte_position_next;
      coord_buf     <= coord_buf_next;
      cmd_buf       <= cmd_buf_next;
      if (done) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      frame <= frame_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scfp_decoder.sv
// Field decoder: converts the three fields of a frame, checks the sum,
// updates the held values and work flag, and registers the result item.
// Uses scfp_pkg.
`default_nettype none

module scfp_decoder
  import scfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        frame_valid,
  input  wire frame_t      frame,
  output logic             frame_ready,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,
  output logic             m_tuser
);

  logic signed [10:0] angle_reg;
  logic signed [10:0] angle_reg_next;
  logic signed [10:0] length_reg;
  logic signed [10:0] length_reg_next;
  logic signed [10:0] sum_reg;
  logic signed [10:0] sum_reg_next;
  logic               work_flag;
  logic               work_flag_next;
  logic signed [10:0] field1;
  logic signed [10:0] field2;
  logic signed [10:0] field3;
  logic               fmt;
  logic               take;
  result_t            result_next;

  assign frame_ready = !m_tvalid || m_tready;
  assign take        = frame_valid && frame_ready;

  // field1 doubles as the command number for command frames
  assign field1 = decode3(frame.bytes[1], frame.bytes[2], frame.bytes[3]);
  assign field2 = decode3(frame.bytes[5], frame.bytes[6], frame.bytes[7]);
  assign field3 = decode3(frame.bytes[9], frame.bytes[10], frame.bytes[11]);
  assign fmt    = (frame.bytes[0] == CH_A) && (frame.bytes[4] == CH_B) &&
                  (frame.bytes[8] == CH_C);

  always_comb begin
    angle_reg_next  = angle_reg;
    length_reg_next = length_reg;
    sum_reg_next    = sum_reg;
    work_flag_next  = work_flag;
    result_next     = '0;
    if (frame.kind == KIND_COORD) begin
      if (fmt) begin
        angle_reg_next  = field1;
        length_reg_next = field2;
        sum_reg_next    = field3;
        result_next.data_valid =
          ({field3[10], field3} == {field1[10], field1} + {field2[10], field2});
      end
      result_next.format_ok = fmt;
    end else begin
      if (field1 == CMD_SET) begin
        work_flag_next = 1'b1;
      end else if (field1 == CMD_CLEAR) begin
        work_flag_next = 1'b0;
      end
      result_next.command_value = field1;
    end
    result_next.angle_value  = angle_reg_next;
    result_next.length_value = length_reg_next;
    result_next.sum_value    = sum_reg_next;
    result_next.work_enable  = work_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reg  <= '0;
      length_reg <= '0;
      sum_reg    <= '0;
      work_flag  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (take) begin
        angle_reg  <= angle_reg_next;
        length_reg <= length_reg_next;
        sum_reg    <= sum_reg_next;
        work_flag  <= work_flag_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= result_next;
      m_tuser <= frame.kind;
    end
  end

endmodule

`default_nettype wire

// File: rtl/serial_coordinate_frame_parser.sv
// Serial coordinate frame parser: received bytes in, one result item per
// completed coordinate or command frame out.
//
// Channels: s_* takes one received byte per item; m_* gives one result
// item per completed frame; cfg_* writes frame_mode (0 coordinate frames
// "aXXXbYYYcZZZ", 1 command frames "sXXX"); the user must write it only
// while the block is idle, which the block itself does not enforce.
// Throughput: one byte per cycle, sustained, when m_tready stays high.
// Path: the byte that completes a frame is accepted and lands in the
// frame register; the decoder then takes it into the result register,
// which drives m_*. Bytes that do not complete a frame give no item.
// The two-register pipeline (frame register, result register) sets the
// latency; the decode of three fields sits between them.
// Stall: with m_tready low the result holds and one more completed frame
// may wait in the frame register; s_tready drops while that register is
// full and the result register cannot take its frame.
// Reset (rst, synchronous): clears byte position, buffers, held angle,
// length and sum, work flag and mode; no item is pending afterwards.
// Depends on scfp_pkg, scfp_assembler, scfp_decoder.
`default_nettype none

module serial_coordinate_frame_parser
  import scfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,    // frame_mode
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // format_ok[0], angle_value[11:1], length_value[22:12], sum_value[33:23],
  // data_valid[34], command_value[45:35], work_enable[46], zero[47]
  output logic [47:0]      m_tdata,
  output logic             m_tuser      // frame_kind
);

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  scfp_assembler u_assembler (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_ready (frame_ready)
  );

  scfp_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_ready (frame_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/scfp_checker.sv
// Port-level checks for the serial coordinate frame parser, bound to the
// top level. Uses scfp_pkg.
`default_nettype none

module scfp_checker
  import scfp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser
);

  result_t r;
  assign r = m_tdata;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item pending after reset");

  a_coord_no_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_COORD |-> r.command_value == '0)
    else $error("coordinate item carries a command number");

  a_cmd_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CMD |-> !r.format_ok && !r.data_valid)
    else $error("command item marks format or data valid");

  a_valid_needs_fmt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.data_valid |-> r.format_ok)
    else $error("data valid without format ok");

endmodule

bind serial_coordinate_frame_parser scfp_checker u_scfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for serial_coordinate_frame_parser: drives bytes and
// frame_mode writes, predicts each result item and checks it field by field.
// Depends on scfp_pkg and the RTL of the parser.
`timescale 1ns / 100ps

module testbench
  import scfp_pkg::*;
();

  typedef struct packed {
    logic               kind;
    logic               fmt;
    logic signed [10:0] angle;
    logic signed [10:0] length;
    logic signed [10:0] sum;
    logic               valid;
    logic signed [10:0] cmd;
    logic               work;
  } frame_result_t;

  typedef struct {
    logic          mode;
    string         text;
    bit            typed;
    frame_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // format_ok[0], angle_value[11:1], length_value[22:12], sum_value[33:23],
  // data_valid[34], command_value[45:35], work_enable[46], zero[47]
  logic [47:0] m_tdata;
  logic        m_tuser;           // frame_kind

  serial_coordinate_frame_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // parser state as the testbench tracks it
  logic               exp_mode = MODE_COORD;
  logic [3:0]         exp_pos = '0;
  logic [7:0]         exp_coord [FrameLen] = '{default: 8'h00};
  logic [7:0]         exp_cmd [CmdLen] = '{default: 8'h00};
  logic signed [10:0] exp_angle = '0;
  logic signed [10:0] exp_length = '0;
  logic signed [10:0] exp_sum = '0;
  logic               exp_work = 1'b0;

  frame_result_t pending_frames[$];
  int            fail_count = 0;
  int            sent_bytes = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          rx_hold = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // three characters, atoi style; f[0] is the first character
  function automatic logic signed [10:0] field_value(input logic [2:0][7:0] f);
    int k;
    bit neg;
    int v;
    k = 0;
    neg = 1'b0;
    v = 0;
    while (k < 3 && (f[k] == CH_SPACE || (f[k] >= CH_TAB && f[k] <= CH_CR))) k++;
    if (k < 3 && (f[k] == CH_PLUS || f[k] == CH_MINUS)) begin
      neg = (f[k] == CH_MINUS);
      k++;
    end
    while (k < 3 && f[k] >= CH_ZERO && f[k] <= CH_NINE) begin
      v = v * 10 + int'(f[k] - CH_ZERO);
      k++;
    end
    return 11'(neg ? -v : v);
  endfunction

  // advance the tracked state by one byte; returns 1 when a frame completes
  function automatic bit parse_byte(input logic [7:0] ch, output frame_result_t res);
    logic signed [10:0] cmd_val;
    bit                 fmt_ok;
    res = '0;
    if (exp_mode == MODE_COORD) begin
      if (ch == CH_A) begin
        exp_coord[0] = ch;
        exp_pos = 4'd1;
        return 1'b0;
      end
      if (exp_pos < FrameLen) begin
        exp_coord[exp_pos] = ch;
        exp_pos++;
        if (exp_pos == FrameLen) begin
          exp_pos = '0;
          fmt_ok = exp_coord[0] == CH_A && exp_coord[4] == CH_B && exp_coord[8] == CH_C;
          if (fmt_ok) begin
            exp_angle  = field_value({exp_coord[3], exp_coord[2], exp_coord[1]});
            exp_length = field_value({exp_coord[7], exp_coord[6], exp_coord[5]});
            exp_sum    = field_value({exp_coord[11], exp_coord[10], exp_coord[9]});
          end
          res = '{KIND_COORD, fmt_ok, exp_angle, exp_length, exp_sum,
                  fmt_ok && (int'(exp_sum) == int'(exp_angle) + int'(exp_length)),
                  11'sd0, exp_work};
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (ch == CH_S) begin
      exp_cmd[0] = ch;
      exp_pos = 4'd1;
      return 1'b0;
    end
    // command bytes count only while a frame start sits in position 0
    if (exp_cmd[0] == CH_S && exp_pos < CmdLen) begin
      exp_cmd[exp_pos[1:0]] = ch;
      exp_pos++;
      if (exp_pos == CmdLen) begin
        exp_pos = '0;
        cmd_val = field_value({exp_cmd[3], exp_cmd[2], exp_cmd[1]});
        if (cmd_val == CMD_SET) exp_work = 1'b1;
        else if (cmd_val == CMD_CLEAR) exp_work = 1'b0;
        res = '{KIND_CMD, 1'b0, exp_angle, exp_length, exp_sum, 1'b0, cmd_val, exp_work};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] ch);
    frame_result_t res;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
    if (parse_byte(ch, res)) pending_frames.push_back(res);
  endtask

  task automatic push_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  function automatic void append_text(inout logic [7:0] seq[$], input string s);
    for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
  endfunction

  // sender stops and waits for every outstanding result
  task automatic wait_until_quiet();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    exp_mode = mode;
  endtask

  // well-formed three-character rendering of v (-99..999), random padding
  function automatic string field_text(input int v);
    int mag;
    mag = (v < 0) ? -v : v;
    if (v < 0)
      return (mag < 10 && $urandom_range(0, 1)) ? $sformatf(" -%0d", mag)
                                                  : $sformatf("-%02d", mag);
    if (mag < 100 && $urandom_range(0, 3) == 0) return $sformatf("+%02d", mag);
    if (mag < 100 && $urandom_range(0, 5) == 0) return $sformatf("\t%2d", mag);
    return $urandom_range(0, 1) ? $sformatf("%3d", mag) : $sformatf("%03d", mag);
  endfunction

  task automatic send_coord_frame(input bit damage);
    int         ang, len, chk;
    logic [7:0] seq[$];
    ang = $urandom_range(0, 598) - 99;
    len = $urandom_range(0, 598) - 99;
    if ($urandom_range(0, 7) == 0) ang = $urandom_range(0, 1098) - 99;
    chk = ang + len;
    if (chk < -99 || chk > 999 || $urandom_range(0, 3) == 0) chk = $urandom_range(0, 1098) - 99;
    append_text(seq, {"a", field_text(ang), "b", field_text(len), "c", field_text(chk)});
    if (damage) begin
      if ($urandom_range(0, 2) == 0) seq = seq[0:$urandom_range(0, 10)];
      else seq[$urandom_range(0, 11)] = 8'($urandom_range(0, 255));
    end
    push_seq(seq);
  endtask

  task automatic send_command_frame(input bit damage);
    int         pick, v;
    logic [7:0] seq[$];
    pick = $urandom_range(0, 9);
    if (pick < 3) v = int'(CMD_SET);
    else if (pick < 6) v = int'(CMD_CLEAR);
    else v = $urandom_range(0, 1098) - 99;
    append_text(seq, {"s", field_text(v)});
    if (damage) seq[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
    push_seq(seq);
  endtask

  task automatic send_noise();
    string      alphabet;
    logic [7:0] seq[$];
    alphabet = " \t+-09abcs";
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 3) != 0) seq.push_back(8'($urandom_range(0, 255)));
      else seq.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
    end
    push_seq(seq);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("result item with none expected");
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        compare_field("frame_kind", want.kind, m_tuser);
        compare_field("format_ok", want.fmt, m_tdata[0]);
        compare_field("angle_value", want.angle, $signed(m_tdata[11:1]));
        compare_field("length_value", want.length, $signed(m_tdata[22:12]));
        compare_field("sum_value", want.sum, $signed(m_tdata[33:23]));
        compare_field("data_valid", want.valid, m_tdata[34]);
        compare_field("command_value", want.cmd, $signed(m_tdata[45:35]));
        compare_field("work_enable", want.work, m_tdata[46]);
      end
    end
  end

  script_row_t script[15];
  int          idle_pct[4]  = '{0, 72, 0, 11};
  int          stall_pct[4] = '{0, 0, 72, 11};

  initial begin
    script = '{
      '{MODE_COORD, "a999b-99c900", 1'b1,
        '{KIND_COORD, 1'b1, 11'sd999, -11'sd99, 11'sd900, 1'b1, 11'sd0, 1'b0}},
      '{MODE_COORD, "a-99b999c900", 1'b1,
        '{KIND_COORD, 1'b1, -11'sd99, 11'sd999, 11'sd900, 1'b1, 11'sd0, 1'b0}},
      '{MODE_COORD, "a000b000c001", 1'b1,
        '{KIND_COORD, 1'b1, 11'sd0, 11'sd0, 11'sd1, 1'b0, 11'sd0, 1'b0}},
      // marker c missing: held values stay
      '{MODE_COORD, "aXXXbYYYxZZZ", 1'b1,
        '{KIND_COORD, 1'b0, 11'sd0, 11'sd0, 11'sd1, 1'b0, 11'sd0, 1'b0}},
      '{MODE_CMD, "s111", 1'b1,
        '{KIND_CMD, 1'b0, 11'sd0, 11'sd0, 11'sd1, 1'b0, 11'sd111, 1'b1}},
      '{MODE_CMD, "s+7 ", 1'b0, '0},
      '{MODE_CMD, "s100", 1'b1,
        '{KIND_CMD, 1'b0, 11'sd0, 11'sd0, 11'sd1, 1'b0, 11'sd100, 1'b0}},
      '{MODE_CMD, "s- \t", 1'b0, '0},               // sign only
      '{MODE_CMD, "xs  9", 1'b0, '0},
      '{MODE_CMD, "s1", 1'b0, '0},                  // left open across the switch
      '{MODE_COORD, "2 b 3 c 15", 1'b0, '0},
      '{MODE_COORD, "a 12b -3c  9", 1'b0, '0},
      '{MODE_COORD, "a1234567", 1'b0, '0},          // position 8 carried over
      '{MODE_CMD, "9s222", 1'b0, '0},
      '{MODE_COORD, "q11b22c33d44", 1'b0, '0}       // position 0 overwritten
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 11;
    recv_stall_pct = 11;
    foreach (script[r]) begin
      if (script[r].mode != exp_mode) begin
        wait_until_quiet();
        set_mode(script[r].mode);
      end
      for (int i = 0; i < script[r].text.len(); i++) push_byte(script[r].text[i]);
      if (script[r].typed) pending_frames[pending_frames.size() - 1] = script[r].want;
    end

    // receiver holds off while the sender streams frames back to back
    wait_until_quiet();
    set_mode(MODE_COORD);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (30) send_coord_frame(1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      int start, pick;
      wait_until_quiet();
      set_mode(ph < 2 ? ph[0] : 1'($urandom_range(0, 1)));
      send_idle_pct  = idle_pct[ph % 4];
      recv_stall_pct = stall_pct[ph % 4];
      start = sent_bytes;
      while (sent_bytes - start < 155) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) send_noise();
        else if (pick < 16) begin
          // frame of the other kind, mostly ignored
          if (exp_mode == MODE_COORD) send_command_frame(1'b0);
          else send_coord_frame(1'b0);
        end else if (exp_mode == MODE_COORD) send_coord_frame(pick < 30);
        else send_command_frame(pick < 26);
      end
    end

    wait_until_quiet();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
